>>> rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator.
// Transaction payload types, operation/status/register codes and fixed widths.
// No dependencies.
package fbpa_pkg;

  localparam int ADDR_W    = 19;
  localparam int CNT_W     = 7;
  localparam int BYTES_W   = 12;
  localparam int STRIDE_W  = BYTES_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;
  localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

  localparam logic [CNT_W-1:0]   RST_BLOCK_COUNT = CNT_W'(64);
  localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = BYTES_W'(16);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_DBL_FREE  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT = 1'd0,
    REG_BLOCK_BYTES = 1'd1
  } reg_idx_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  used_count;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic find;
    logic alloc;
    logic div_step;
    logic free;
    logic clear;
    logic nop;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

>>> rtl/fbpa_ctrl.sv
// Sequencer for the fixed block pool allocator.
// Steps one transaction through find/commit/divide states and owns out_valid.
// Depends on fbpa_pkg.
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  op_t  in_op,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output logic cfg_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ALLOC,
    S_DIV,
    S_FREE,
    S_CLEAR,
    S_NOP,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_op)
            OP_ALLOC: state_nxt = S_FIND;
            OP_FREE:  state_nxt = S_DIV;
            OP_CLEAR: state_nxt = S_CLEAR;
            default:  state_nxt = S_NOP;
          endcase
        end
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FREE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FREE: begin
        cmd.free  = 1'b1;
        state_nxt = S_OUT;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_OUT;
      end
      S_NOP: begin
        cmd.nop   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_free_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE) |-> $past(sts.div_done))
    else $error("free committed before division finished");

endmodule

>>> rtl/fbpa_dp.sv
// Datapath for the fixed block pool allocator.
// Busy bits, use count, config registers, lowest-free search, stride multiply,
// bit-serial divider and result register. Depends on fbpa_pkg.
module fbpa_dp import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS      = 64,
  parameter int MAX_BLOCK_BYTES = 4095
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int PROD_W = CNT_W + STRIDE_W;

  logic [MAX_BLOCKS-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      cfg_count_r;
  logic [BYTES_W-1:0]    cfg_bytes_r;

  logic [CNT_W-1:0]      eff_count;
  logic [BYTES_W-1:0]    eff_bytes;
  logic [STRIDE_W-1:0]   stride;
  logic [MAX_BLOCKS-1:0] in_rng;

  logic [IDX_W-1:0]      find_idx_r, find_idx;
  logic                  find_ok_r, find_ok;
  logic [PROD_W-1:0]     prod;

  logic [ADDR_W-1:0]     quo_r;
  logic [STRIDE_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  addr_zero_r;
  logic [STRIDE_W:0]     shift;
  logic [STRIDE_W+1:0]   diff;
  logic                  ge;

  logic [IDX_W-1:0]      free_idx;
  logic                  free_rng;
  out_item_t             res_r, res_nxt;
  out_item_t             out_r;

  always_comb begin
    eff_count = cfg_count_r;
    if (32'(cfg_count_r) > MAX_BLOCKS) begin
      eff_count = CNT_W'(MAX_BLOCKS);
    end
    eff_bytes = cfg_bytes_r;
    if (cfg_bytes_r == '0) begin
      eff_bytes = BYTES_W'(1);
    end else if (32'(cfg_bytes_r) > MAX_BLOCK_BYTES) begin
      eff_bytes = BYTES_W'(MAX_BLOCK_BYTES);
    end
    stride = STRIDE_W'(eff_bytes) + STRIDE_W'(1);
  end

  always_comb begin
    find_idx = '0;
    find_ok  = 1'b0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      in_rng[i] = (i < 32'(eff_count));
    end
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (in_rng[i] && !busy_r[i]) begin
        find_idx = IDX_W'(i);
        find_ok  = 1'b1;
      end
    end
  end

  assign prod = PROD_W'(CNT_W'(find_idx_r)) * PROD_W'(stride);

  // restoring divider step
  assign shift = {rem_r, quo_r[ADDR_W-1]};
  assign diff  = {1'b0, shift} - {2'b00, stride};
  assign ge    = !diff[STRIDE_W+1];
  assign sts.div_done = (cnt_r == '0);

  assign free_idx = quo_r[IDX_W-1:0];
  assign free_rng = !addr_zero_r && (rem_r == '0) && (quo_r < ADDR_W'(eff_count));

  always_comb begin
    busy_nxt = busy_r;
    used_nxt = used_r;
    res_nxt  = res_r;
    if (cmd.alloc) begin
      res_nxt.block_address = '0;
      res_nxt.status        = ST_FULL;
      if (find_ok_r) begin
        busy_nxt[find_idx_r]  = 1'b1;
        used_nxt              = used_r + CNT_W'(1);
        res_nxt.block_address = ADDR_W'(prod + PROD_W'(1));
        res_nxt.status        = ST_OK;
      end
      res_nxt.used_count = used_nxt;
    end
    if (cmd.free) begin
      res_nxt.block_address = '0;
      if (!free_rng) begin
        res_nxt.status = ST_BAD_ADDR;
      end else if (!busy_r[free_idx]) begin
        res_nxt.status = ST_DBL_FREE;
      end else begin
        busy_nxt[free_idx] = 1'b0;
        used_nxt           = used_r - CNT_W'(1);
        res_nxt.status     = ST_OK;
      end
      res_nxt.used_count = used_nxt;
    end
    if (cmd.clear) begin
      busy_nxt = '0;
      used_nxt = '0;
    end
    if (cmd.clear || cmd.nop) begin
      res_nxt.status        = ST_OK;
      res_nxt.block_address = '0;
      res_nxt.used_count    = used_nxt;
    end
    if (cfg_we) begin
      busy_nxt = '0;
      used_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      used_r      <= '0;
      cfg_count_r <= RST_BLOCK_COUNT;
      cfg_bytes_r <= RST_BLOCK_BYTES;
      cnt_r       <= '0;
    end else begin
      busy_r <= busy_nxt;
      used_r <= used_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BLOCK_COUNT: cfg_count_r <= cfg_data[CNT_W-1:0];
          REG_BLOCK_BYTES: cfg_bytes_r <= cfg_data[BYTES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        cnt_r <= DIV_CNT_W'(ADDR_W);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.find) begin
      find_idx_r <= find_idx;
      find_ok_r  <= find_ok;
    end
    if (cmd.accept) begin
      quo_r       <= in_data.address - ADDR_W'(1);
      rem_r       <= '0;
      addr_zero_r <= (in_data.address == '0);
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[ADDR_W-2:0], ge};
      rem_r <= ge ? diff[STRIDE_W-1:0] : shift[STRIDE_W-1:0];
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) == $countones(busy_r))
    else $error("use count differs from busy bits");

  a_busy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r & ~in_rng) == '0)
    else $error("busy bit set beyond block count");

  a_full_means_all_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alloc && !find_ok_r) |-> (used_r == eff_count))
    else $error("pool full reported with free blocks");

endmodule

>>> rtl/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool allocator, top level.
// Allocate: lowest-free search, then stride multiply.
// Free: offset/stride division by the 19-step bit-serial divider.
// Clear and unused op: no search or divide. A new request is taken while a result waits.
// Synchronous active-low reset: all blocks free, count 0, block_count 64, block_bytes 16.
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS      = 64,
  parameter int MAX_BLOCK_BYTES = 4095
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> tb/fixed_block_pool_allocator_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for fixed_block_pool_allocator_unit: directed and random
// allocate/free/clear traffic across many pool settings, checked by a scoreboard class.
// Depends on fbpa_pkg and the allocator RTL only.
module fixed_block_pool_allocator_unit_test;
  import fbpa_pkg::*;

  localparam int POOL_BLOCKS    = 64;
  localparam int POOL_MAX_BYTES = 4095;
  localparam int SEGMENTS       = 19;
  localparam int SEG_ITEMS      = 50;
  localparam int DRAIN_CYCLES   = 30;
  localparam int CYCLE_LIMIT    = 400000;

  class pool_scoreboard;
    logic [63:0]        busy_map;
    logic [CNT_W-1:0]   in_use;
    logic [CNT_W-1:0]   count_reg;
    logic [BYTES_W-1:0] bytes_reg;
    out_item_t          expected_q[$];
    int                 errors;
    int                 requests;
    int                 results;
    int                 reg_writes;
    int                 status_seen[4];

    function new();
      busy_map   = '0;
      in_use     = '0;
      count_reg  = RST_BLOCK_COUNT;
      bytes_reg  = RST_BLOCK_BYTES;
      errors     = 0;
      requests   = 0;
      results    = 0;
      reg_writes = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pool_blocks();
      return (count_reg > POOL_BLOCKS) ? POOL_BLOCKS : int'(count_reg);
    endfunction

    function int stride();
      int b;
      b = (bytes_reg == 0) ? 1 : int'(bytes_reg);
      if (b > POOL_MAX_BYTES) b = POOL_MAX_BYTES;
      return b + 1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_register(reg_idx_t idx, logic [CFG_DAT_W-1:0] data);
      if (idx == REG_BLOCK_COUNT) count_reg = data[CNT_W-1:0];
      else bytes_reg = data[BYTES_W-1:0];
      busy_map = '0;
      in_use   = '0;
      reg_writes++;
    endfunction

    function void note_request(in_item_t req);
      out_item_t exp_item;
      int        blocks;
      int        step;
      int        offset;
      int        idx;
      bit        found;
      blocks = pool_blocks();
      step   = stride();
      exp_item.status        = ST_OK;
      exp_item.block_address = '0;
      found = 1'b0;
      case (req.op)
        OP_ALLOC: begin
          for (int i = 0; i < blocks && !found; i++) begin
            if (!busy_map[i]) begin
              busy_map[i] = 1'b1;
              in_use++;
              exp_item.block_address = ADDR_W'(i * step + 1);
              found = 1'b1;
            end
          end
          if (!found) exp_item.status = ST_FULL;
        end
        OP_FREE: begin
          if (req.address == 0) begin
            exp_item.status = ST_BAD_ADDR;
          end else begin
            offset = int'(req.address) - 1;
            idx    = offset / step;
            if ((offset % step) != 0 || idx >= blocks) begin
              exp_item.status = ST_BAD_ADDR;
            end else if (!busy_map[idx]) begin
              exp_item.status = ST_DBL_FREE;
            end else begin
              busy_map[idx] = 1'b0;
              in_use--;
            end
          end
        end
        OP_CLEAR: begin
          busy_map = '0;
          in_use   = '0;
        end
        default: ;
      endcase
      exp_item.used_count = in_use;
      expected_q.push_back(exp_item);
      requests++;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results++;
      status_seen[got.status]++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d addr=%0d used=%0d",
                                  got.status, got.block_address, got.used_count));
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.block_address !== want.block_address)
          report_mismatch($sformatf("block_address got %0d want %0d",
                                    got.block_address, want.block_address));
        if (got.used_count !== want.used_count)
          report_mismatch($sformatf("used_count got %0d want %0d",
                                    got.used_count, want.used_count));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int cycle_count  = 0;

  pool_scoreboard sb = new();

  fixed_block_pool_allocator_unit #(
    .MAX_BLOCKS     (POOL_BLOCKS),
    .MAX_BLOCK_BYTES(POOL_MAX_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(input in_item_t req);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic send_op(input op_t op, input int addr);
    in_item_t req;
    req.op      = op;
    req.address = ADDR_W'(addr);
    send_request(req);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_block_count();
    logic [CNT_W-1:0] n;
    case ($urandom_range(9))
      0:       n = 0;
      1:       n = 1;
      2:       n = 2;
      3, 4:    n = CNT_W'($urandom_range(3, 8));
      5:       n = CNT_W'(POOL_BLOCKS);
      6:       n = CNT_W'($urandom_range(POOL_BLOCKS + 1, 127));
      default: n = CNT_W'($urandom_range(1, POOL_BLOCKS));
    endcase
    return {(CFG_DAT_W-CNT_W)'($urandom_range(0, 31)), n};
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_block_bytes();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 1;
      2:       return CFG_DAT_W'(POOL_MAX_BYTES);
      3, 4, 5: return CFG_DAT_W'($urandom_range(1, 40));
      default: return CFG_DAT_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int       r;
    int       idx;
    int       aligned;
    r = $urandom_range(99);
    req.address = ADDR_W'($urandom);
    if (r < 45) begin
      req.op = OP_ALLOC;
    end else if (r < 91) begin
      req.op  = OP_FREE;
      idx     = $urandom_range(0, sb.pool_blocks());
      aligned = idx * sb.stride() + 1;
      r       = $urandom_range(99);
      if (r < 5) req.address = '0;
      else if (r < 70) req.address = ADDR_W'(aligned);
      else if (r < 80) req.address = ADDR_W'($urandom_range(0, 1) ? aligned + 1 : aligned - 1);
    end else if (r < 95) begin
      req.op = OP_CLEAR;
    end else begin
      req.op = OP_NONE;
    end
    return req;
  endfunction

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BLOCK_COUNT;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 37;
    out_idle_pct = 47;
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 'h7FFFF);
    send_op(OP_FREE, 1);
    send_op(OP_FREE, 1);
    send_op(OP_FREE, 0);
    send_op(OP_FREE, 2);
    send_op(OP_FREE, POOL_BLOCKS * 17 + 1);
    send_op(OP_FREE, 'h7FFFF);
    send_op(OP_NONE, 'h7FFFF);
    send_op(OP_FREE, 18);
    send_op(OP_ALLOC, 0);
    send_op(OP_CLEAR, 0);
    send_op(OP_FREE, 1);

    write_register(REG_BLOCK_COUNT, 1);
    write_register(REG_BLOCK_BYTES, 0);
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 0);
    send_op(OP_FREE, 1);

    write_register(REG_BLOCK_COUNT, 127);
    write_register(REG_BLOCK_BYTES, CFG_DAT_W'(POOL_MAX_BYTES));
    send_op(OP_FREE, 63 * 4096 + 1);
    send_op(OP_FREE, 64 * 4096 + 1);
    send_op(OP_ALLOC, 0);

    write_register(REG_BLOCK_COUNT, 0);
    send_op(OP_ALLOC, 0);
    send_op(OP_FREE, 1);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 7) begin
        in_idle_pct  = 37;
        out_idle_pct = 47;
      end else if (seg < 14) begin
        in_idle_pct  = 47;
        out_idle_pct = 37;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if ($urandom_range(3) != 0) write_register(REG_BLOCK_COUNT, pick_block_count());
      if ($urandom_range(3) != 0) write_register(REG_BLOCK_BYTES, pick_block_bytes());
      for (int n = 0; n < SEG_ITEMS; n++) send_request(random_request());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests and %0d results through %0d register writes",
             sb.requests, sb.results, sb.reg_writes);
    $display("Status mix ok/full/bad-address/double-free: %0d/%0d/%0d/%0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
